[design/tpd_pkg.sv]
// Shared types, constants and defaults of the periodic task dispatcher.
package tpd_pkg;

  localparam int GROUPS_DEF          = 4;
  localparam int TASKS_PER_GROUP_DEF = 16;

  // Field widths fixed by the item format.
  localparam int TICK_W  = 16;
  localparam int CMD_W   = 2;
  localparam int GROUP_W = 2;
  localparam int SLOT_W  = 4;
  localparam int CFG_W   = 16;
  localparam int GUSE_W  = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_START_DEV   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUPS_USED = 1'b1;

  localparam logic [TICK_W-1:0] START_DEV_RST   = 16'd2;
  localparam logic [GUSE_W-1:0] GROUPS_USED_RST = 3'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD     = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_DISPATCH = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DISP,
    ST_DISP_RES,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load;
    logic scan;
    logic disp_find;
    logic disp_res;
    logic out_load;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
  } stat_t;

endpackage

[design/tick_periodic_task_dispatcher.sv]
// A tick scans N = min(groups_in_use, GROUPS) * TASKS_PER_GROUP table entries, read one per cycle.
// The block takes one item at a time: the next transfer is accepted once the result is loaded
// into the output register, and a result held there by out_ready_i low stalls it.
// Reset: asynchronous, clears ticker, masks and handshake state; table needs no clearing.
module tick_periodic_task_dispatcher import tpd_pkg::*; #(
  parameter int GROUPS          = GROUPS_DEF,
  parameter int TASKS_PER_GROUP = TASKS_PER_GROUP_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [GROUP_W-1:0]   group_i,
  input  logic [SLOT_W-1:0]    task_slot_i,
  input  logic [TICK_W-1:0]    first_tick_i,
  input  logic [TICK_W-1:0]    period_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 found_o,
  output logic [GROUP_W-1:0]   chosen_group_o,
  output logic [SLOT_W-1:0]    chosen_slot_o,
  output logic                 retired_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  ctrl_t ctrl;
  stat_t stat;

  tpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  tpd_datapath #(
    .GROUPS          (GROUPS),
    .TASKS_PER_GROUP (TASKS_PER_GROUP)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .command_i      (command_i),
    .group_i        (group_i),
    .task_slot_i    (task_slot_i),
    .first_tick_i   (first_tick_i),
    .period_i       (period_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .found_o        (found_o),
    .chosen_group_o (chosen_group_o),
    .chosen_slot_o  (chosen_slot_o),
    .retired_o      (retired_o)
  );

endmodule

[design/tpd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/tpd_ctrl.sv]
// Controller state machine of the periodic task dispatcher.
module tpd_ctrl import tpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CMD_W-1:0] command_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  stat_t            stat_i,
  output ctrl_t            ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.accept = 1'b1;
          case (command_i)
            CMD_LOAD:     state_d = ST_LOAD;
            CMD_TICK:     state_d = ST_SCAN;
            CMD_DISPATCH: state_d = ST_DISP;
            default:      state_d = ST_FINISH;
          endcase
        end
      end
      ST_LOAD: begin
        ctrl_o.load = 1'b1;
        state_d     = ST_FINISH;
      end
      ST_SCAN: begin
        ctrl_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_DISP: begin
        ctrl_o.disp_find = 1'b1;
        state_d          = ST_DISP_RES;
      end
      ST_DISP_RES: begin
        ctrl_o.disp_res = 1'b1;
        state_d         = ST_FINISH;
      end
      ST_FINISH: begin
        // hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[design/tpd_datapath.sv]
// Datapath: task table, masks, ticker, scan pipeline, dispatch pick and result.
module tpd_datapath import tpd_pkg::*; #(
  parameter int GROUPS          = GROUPS_DEF,
  parameter int TASKS_PER_GROUP = TASKS_PER_GROUP_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  output stat_t              stat_o,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [GROUP_W-1:0] group_i,
  input  logic [SLOT_W-1:0]  task_slot_i,
  input  logic [TICK_W-1:0]  first_tick_i,
  input  logic [TICK_W-1:0]  period_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic               found_o,
  output logic [GROUP_W-1:0] chosen_group_o,
  output logic [SLOT_W-1:0]  chosen_slot_o,
  output logic               retired_o
);

  localparam int ENTRIES = GROUPS * TASKS_PER_GROUP;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AW1     = AW + 1;
  localparam int GIW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int SIW     = (TASKS_PER_GROUP > 1) ? $clog2(TASKS_PER_GROUP) : 1;
  localparam int GCW     = $clog2(GROUPS + 1);
  localparam int NW      = (GCW > GUSE_W) ? GCW : GUSE_W;
  localparam int DW      = 2 * TICK_W;

  // Configuration registers
  logic [TICK_W-1:0] dev_q;
  logic [GUSE_W-1:0] gu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q <= START_DEV_RST;
      gu_q  <= GROUPS_USED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_DEV:   dev_q <= cfg_data_i;
        CFG_GROUPS_USED: gu_q  <= cfg_data_i[GUSE_W-1:0];
        default: ;
      endcase
    end
  end

  // Latched input item
  logic [GROUP_W-1:0] grp_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [TICK_W-1:0]  first_q;
  logic [TICK_W-1:0]  per_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      grp_q   <= group_i;
      slot_q  <= task_slot_i;
      first_q <= first_tick_i;
      per_q   <= period_i;
    end
  end

  logic [TICK_W-1:0] ticker_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticker_q <= '0;
    end else if (ctrl_i.accept && (command_i == CMD_TICK)) begin
      ticker_q <= ticker_q + 1'b1;
    end
  end

  // Task table: {start tick, period} per entry
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;
  logic [TICK_W-1:0] rd_start;
  logic [TICK_W-1:0] rd_per;

  tpd_ram #(
    .WIDTH (DW),
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  assign rd_start = ram_rdata[DW-1:TICK_W];
  assign rd_per   = ram_rdata[TICK_W-1:0];

  // Masks
  logic [GROUPS-1:0][TASKS_PER_GROUP-1:0] en_q;
  logic [GROUPS-1:0][TASKS_PER_GROUP-1:0] un_q;
  logic [GROUPS-1:0][TASKS_PER_GROUP-1:0] act_q;

  // Load
  logic          load_ok;
  logic [GIW-1:0] ld_g;
  logic [SIW-1:0] ld_s;
  logic [AW-1:0]  ld_addr;

  assign load_ok = (int'(grp_q) < GROUPS) && (int'(slot_q) < TASKS_PER_GROUP);
  assign ld_g    = GIW'(grp_q);
  assign ld_s    = SIW'(slot_q);
  assign ld_addr = AW'(AW1'(ld_g) * AW1'(TASKS_PER_GROUP) + AW1'(ld_s));

  // Scan: issue one read per cycle, evaluate the entry read the cycle before
  logic [GCW-1:0] sg_q;
  logic [SIW-1:0] ss_q;
  logic           issue;
  logic [AW-1:0]  scan_addr;
  logic           ev_v_q;
  logic [GIW-1:0] ev_g_q;
  logic [SIW-1:0] ev_s_q;
  logic [AW-1:0]  ev_addr_q;
  logic           ev_en;
  logic           ev_un;
  logic [TICK_W-1:0] ev_d;
  logic           ev_first;
  logic           ev_period;

  assign issue = ctrl_i.scan && (NW'(sg_q) < NW'(gu_q)) && (sg_q < GCW'(GROUPS));
  assign scan_addr = AW'(AW1'(sg_q) * AW1'(TASKS_PER_GROUP) + AW1'(ss_q));
  assign stat_o.scan_done = !issue && !ev_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sg_q   <= '0;
      ss_q   <= '0;
      ev_v_q <= 1'b0;
    end else begin
      ev_v_q <= issue;
      if (ctrl_i.accept) begin
        sg_q <= '0;
        ss_q <= '0;
      end else if (issue) begin
        if (ss_q == SIW'(TASKS_PER_GROUP - 1)) begin
          ss_q <= '0;
          sg_q <= sg_q + 1'b1;
        end else begin
          ss_q <= ss_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      ev_g_q    <= GIW'(sg_q);
      ev_s_q    <= ss_q;
      ev_addr_q <= scan_addr;
    end
  end

  assign ev_en     = ev_v_q && en_q[ev_g_q][ev_s_q];
  assign ev_un     = un_q[ev_g_q][ev_s_q];
  assign ev_d      = ticker_q - rd_start;
  assign ev_first  = ev_en && ev_un && (ev_d <= dev_q);
  assign ev_period = ev_en && !ev_un && (ev_d >= rd_per);

  // Dispatch pick: first group in use with an active task, lowest slot in it
  logic           df_found;
  logic [GIW-1:0] df_g;
  logic [SIW-1:0] df_s;
  logic [TASKS_PER_GROUP-1:0] df_act;
  logic [AW-1:0]  df_addr;
  logic           dfound_q;
  logic [GIW-1:0] dg_q;
  logic [SIW-1:0] ds_q;

  always_comb begin
    df_found = 1'b0;
    df_g     = '0;
    for (int g = 0; g < GROUPS; g++) begin
      if (!df_found && (g < int'(gu_q)) && (|act_q[g])) begin
        df_found = 1'b1;
        df_g     = GIW'(g);
      end
    end
  end

  assign df_act = act_q[df_g];

  always_comb begin
    df_s = '0;
    for (int s = TASKS_PER_GROUP - 1; s >= 0; s--) begin
      if (df_act[s]) begin
        df_s = SIW'(s);
      end
    end
  end

  assign df_addr = AW'(AW1'(df_g) * AW1'(TASKS_PER_GROUP) + AW1'(df_s));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dfound_q <= 1'b0;
    end else if (ctrl_i.disp_find) begin
      dfound_q <= df_found;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.disp_find) begin
      dg_q <= df_g;
      ds_q <= df_s;
    end
  end

  // Table port selection
  always_comb begin
    ram_raddr = ctrl_i.disp_find ? df_addr : scan_addr;
    ram_we    = 1'b0;
    ram_waddr = ld_addr;
    ram_wdata = {first_q, per_q};
    if (ctrl_i.load && load_ok) begin
      ram_we = 1'b1;
    end else if (ev_period) begin
      // advance the start tick by one period
      ram_we    = 1'b1;
      ram_waddr = ev_addr_q;
      ram_wdata = {rd_start + rd_per, rd_per};
    end
  end

  // Mask updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= '0;
      un_q  <= '0;
      act_q <= '0;
    end else begin
      if (ctrl_i.load && load_ok) begin
        en_q[ld_g][ld_s]  <= 1'b1;
        un_q[ld_g][ld_s]  <= 1'b1;
        act_q[ld_g][ld_s] <= 1'b0;
      end
      if (ev_first) begin
        un_q[ev_g_q][ev_s_q]  <= 1'b0;
        act_q[ev_g_q][ev_s_q] <= 1'b1;
      end
      if (ev_period) begin
        act_q[ev_g_q][ev_s_q] <= 1'b1;
      end
      if (ctrl_i.disp_res && dfound_q) begin
        act_q[dg_q][ds_q] <= 1'b0;
        if (rd_per == '0) begin
          en_q[dg_q][ds_q] <= 1'b0;
        end
      end
    end
  end

  // Pending result and output register
  logic               res_found_q;
  logic [GROUP_W-1:0] res_g_q;
  logic [SLOT_W-1:0]  res_s_q;
  logic               res_ret_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      res_found_q <= 1'b0;
      res_g_q     <= '0;
      res_s_q     <= '0;
      res_ret_q   <= 1'b0;
    end else if (ctrl_i.disp_res && dfound_q) begin
      res_found_q <= 1'b1;
      res_g_q     <= GROUP_W'(dg_q);
      res_s_q     <= SLOT_W'(ds_q);
      res_ret_q   <= (rd_per == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      found_o        <= res_found_q;
      chosen_group_o <= res_g_q;
      chosen_slot_o  <= res_s_q;
      retired_o      <= res_ret_q;
    end
  end

endmodule

[sim/dispatcher_checker.sv]
// Channel monitor for the task dispatcher: predicts each result and compares it.
module dispatcher_checker import tpd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [GROUP_W-1:0]   group_i,
  input  logic [SLOT_W-1:0]    task_slot_i,
  input  logic [TICK_W-1:0]    first_tick_i,
  input  logic [TICK_W-1:0]    period_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 found_i,
  input  logic [GROUP_W-1:0]   chosen_group_i,
  input  logic [SLOT_W-1:0]    chosen_slot_i,
  input  logic                 retired_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   mismatch_count_o,
  output int                   pending_o
);

  localparam int GROUPS = GROUPS_DEF;
  localparam int TPG    = TASKS_PER_GROUP_DEF;

  typedef struct packed {
    logic               found;
    logic [GROUP_W-1:0] grp;
    logic [SLOT_W-1:0]  slot;
    logic               retired;
  } pick_t;

  logic [TICK_W-1:0] start_dev;
  logic [GUSE_W-1:0] groups_used;
  logic [TICK_W-1:0] ticker;
  logic [TICK_W-1:0] start_tick [GROUPS*TPG];
  logic [TICK_W-1:0] period_of  [GROUPS*TPG];
  logic [TPG-1:0]    enabled    [GROUPS];
  logic [TPG-1:0]    unstarted  [GROUPS];
  logic [TPG-1:0]    active     [GROUPS];
  pick_t             expected_picks [$];
  int                mismatches = 0;
  int                waiting = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = waiting;

  function automatic int scanned_groups();
    return (groups_used > GROUPS) ? GROUPS : int'(groups_used);
  endfunction

  // Apply one command to the task table copy and return the pick it reports.
  function automatic pick_t predict_pick(logic [CMD_W-1:0] cmd, logic [GROUP_W-1:0] grp,
                                         logic [SLOT_W-1:0] slot, logic [TICK_W-1:0] first,
                                         logic [TICK_W-1:0] per);
    pick_t             pick;
    int                n;
    int                idx;
    int                sel;
    logic [TICK_W-1:0] d;
    bit                done;
    pick = '0;
    n    = scanned_groups();
    done = 1'b0;
    sel  = 0;
    case (cmd)
      CMD_LOAD: begin
        idx = grp * TPG + slot;
        start_tick[idx]      = first;
        period_of[idx]       = per;
        enabled[grp][slot]   = 1'b1;
        unstarted[grp][slot] = 1'b1;
        active[grp][slot]    = 1'b0;
      end
      CMD_TICK: begin
        ticker = ticker + 1'b1;
        for (int g = 0; g < n; g++) begin
          for (int s = 0; s < TPG; s++) begin
            if (enabled[g][s]) begin
              idx = g * TPG + s;
              d   = ticker - start_tick[idx];
              if (unstarted[g][s]) begin
                // first run: within the deviation window after the start tick
                if (d <= start_dev) begin
                  unstarted[g][s] = 1'b0;
                  active[g][s]    = 1'b1;
                end
              end else if (d >= period_of[idx]) begin
                active[g][s]    = 1'b1;
                start_tick[idx] = start_tick[idx] + period_of[idx];
              end
            end
          end
        end
      end
      CMD_DISPATCH: begin
        for (int g = 0; g < n; g++) begin
          if (!done && active[g] != '0) begin
            for (int s = TPG - 1; s >= 0; s--) begin
              if (active[g][s]) sel = s;
            end
            active[g][sel] = 1'b0;
            pick.found = 1'b1;
            pick.grp   = GROUP_W'(g);
            pick.slot  = SLOT_W'(sel);
            // one-shot tasks leave the table
            if (period_of[g * TPG + sel] == '0) begin
              enabled[g][sel] = 1'b0;
              pick.retired    = 1'b1;
            end
            done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return pick;
  endfunction

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      if (mismatches < 10)
        $display("%s mismatch: expected %0d, got %0d", what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pick_t want;
    pick_t got;
    if (!rst_ni) begin
      start_dev   = START_DEV_RST;
      groups_used = GROUPS_USED_RST;
      ticker      = '0;
      for (int i = 0; i < GROUPS * TPG; i++) begin
        start_tick[i] = '0;
        period_of[i]  = '0;
      end
      for (int g = 0; g < GROUPS; g++) begin
        enabled[g]   = '0;
        unstarted[g] = '0;
        active[g]    = '0;
      end
      expected_picks.delete();
      waiting = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_START_DEV) start_dev = cfg_data_i;
        else if (cfg_idx_i == CFG_GROUPS_USED) groups_used = cfg_data_i[GUSE_W-1:0];
      end
      if (in_valid_i && in_ready_i)
        expected_picks.push_back(predict_pick(command_i, group_i, task_slot_i,
                                              first_tick_i, period_i));
      if (out_valid_i && out_ready_i) begin
        got = '{found_i, chosen_group_i, chosen_slot_i, retired_i};
        if (expected_picks.size() == 0) begin
          if (mismatches < 10)
            $display("result with no prediction: found %0d group %0d slot %0d retired %0d",
                     got.found, got.grp, got.slot, got.retired);
          mismatches++;
        end else begin
          want = expected_picks.pop_front();
          check_field("found", want.found, got.found);
          check_field("chosen_group", want.grp, got.grp);
          check_field("chosen_slot", want.slot, got.slot);
          check_field("retired", want.retired, got.retired);
        end
      end
      waiting = expected_picks.size();
    end
  end

endmodule

[sim/testbench.sv]
// Stimulus and verdict for the periodic task dispatcher regression.
module testbench;
  import tpd_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [CMD_W-1:0]     command_i;
  logic [GROUP_W-1:0]   group_i;
  logic [SLOT_W-1:0]    task_slot_i;
  logic [TICK_W-1:0]    first_tick_i;
  logic [TICK_W-1:0]    period_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 found_o;
  logic [GROUP_W-1:0]   chosen_group_o;
  logic [SLOT_W-1:0]    chosen_slot_o;
  logic                 retired_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  int                   mismatches;
  int                   pending;

  logic [TICK_W-1:0] ticks_sent = '0;
  bit                in_calm = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  tick_periodic_task_dispatcher u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .group_i, .task_slot_i,
    .first_tick_i, .period_i, .out_valid_o, .out_ready_i, .found_o, .chosen_group_o,
    .chosen_slot_o, .retired_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  dispatcher_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i,
    .in_ready_i       (in_ready_o),
    .command_i, .group_i, .task_slot_i, .first_tick_i, .period_i,
    .out_valid_i      (out_valid_o),
    .out_ready_i,
    .found_i          (found_o),
    .chosen_group_i   (chosen_group_o),
    .chosen_slot_i    (chosen_slot_o),
    .retired_i        (retired_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // Present one command, hold it until the transfer, then draw the gap to the next.
  task automatic send(logic [CMD_W-1:0] cmd, logic [GROUP_W-1:0] grp, logic [SLOT_W-1:0] slot,
                      logic [TICK_W-1:0] first, logic [TICK_W-1:0] per);
    int gap;
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    group_i      <= grp;
    task_slot_i  <= slot;
    first_tick_i <= first;
    period_i     <= per;
    do @(posedge clk_i); while (!in_ready_o);
    if (cmd == CMD_TICK) ticks_sent = ticks_sent + 1'b1;
    if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off the sender until every predicted result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(logic [TICK_W-1:0] dev, logic [GUSE_W-1:0] groups);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_START_DEV;
    cfg_data_i <= dev;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_GROUPS_USED;
    cfg_data_i <= CFG_W'(groups);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Ticks and dispatches dominate; loads mostly start near the current tick, often with
  // short periods, so tasks fire; the rest: far-off starts, long periods, stray commands.
  task automatic random_item();
    int                r;
    logic [TICK_W-1:0] first;
    logic [TICK_W-1:0] per;
    r = $urandom_range(0, 99);
    if (r < 18) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: first = ticks_sent + TICK_W'($urandom_range(0, 4));
        6, 7:             first = ticks_sent - TICK_W'($urandom_range(0, 20));
        default:          first = TICK_W'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: per = TICK_W'($urandom_range(1, 6));
        4, 5:       per = '0;
        6, 7:       per = TICK_W'($urandom_range(7, 40));
        default:    per = TICK_W'($urandom);
      endcase
      send(CMD_LOAD, GROUP_W'($urandom), SLOT_W'($urandom), first, per);
    end else if (r < 60) begin
      send(CMD_TICK, GROUP_W'($urandom), SLOT_W'($urandom), TICK_W'($urandom),
           TICK_W'($urandom));
    end else if (r < 98) begin
      send(CMD_DISPATCH, GROUP_W'($urandom), SLOT_W'($urandom), TICK_W'($urandom),
           TICK_W'($urandom));
    end else begin
      send(CMD_UNUSED, GROUP_W'($urandom), SLOT_W'($urandom), TICK_W'($urandom),
           TICK_W'($urandom));
    end
  endtask

  initial begin : result_sink
    int stall;
    bit calm;
    calm = 1'b0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    logic [TICK_W-1:0] dev_sel;
    logic [GUSE_W-1:0] groups_sel;
    int                count;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    command_i    <= CMD_LOAD;
    group_i      <= '0;
    task_slot_i  <= '0;
    first_tick_i <= '0;
    period_i     <= '0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_START_DEV;
    cfg_data_i   <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset configuration
    send(CMD_DISPATCH, 2'd0, 4'd0, 16'd0, 16'd0);           // empty table
    send(CMD_UNUSED, 2'd3, 4'd15, 16'hFFFF, 16'hFFFF);
    send(CMD_LOAD, 2'd3, 4'd15, 16'd1, 16'd0);              // last slot, one-shot
    send(CMD_LOAD, 2'd0, 4'd0, 16'd1, 16'd1);
    send(CMD_LOAD, 2'd1, 4'd7, 16'hFFFF, 16'hFFFF);         // start before the ticker wraps
    send(CMD_LOAD, 2'd2, 4'd8, 16'd0, 16'd0);
    send(CMD_TICK, 2'd0, 4'd0, 16'd0, 16'd0);
    repeat (5) send(CMD_DISPATCH, 2'd0, 4'd0, 16'd0, 16'd0);
    send(CMD_TICK, 2'd0, 4'd0, 16'd0, 16'd0);
    send(CMD_LOAD, 2'd0, 4'd0, 16'd2, 16'd3);               // reload clears pending run
    send(CMD_DISPATCH, 2'd0, 4'd0, 16'd0, 16'd0);
    send(CMD_TICK, 2'd0, 4'd0, 16'd0, 16'd0);
    send(CMD_LOAD, 2'd0, 4'd5, 16'd0, 16'd0);               // start already missed
    send(CMD_TICK, 2'd0, 4'd0, 16'd0, 16'd0);
    send(CMD_DISPATCH, 2'd0, 4'd0, 16'd0, 16'd0);
    send(CMD_LOAD, 2'd0, 4'd1, 16'd5, 16'd0);
    send(CMD_LOAD, 2'd0, 4'd2, 16'd5, 16'd2);
    send(CMD_TICK, 2'd0, 4'd0, 16'd0, 16'd0);
    repeat (3) send(CMD_DISPATCH, 2'd0, 4'd0, 16'd0, 16'd0);

    for (int p = 0; p < 7; p++) begin
      drain();
      case (p)
        0: begin dev_sel = 16'd2;                        groups_sel = 3'd4; end
        1: begin dev_sel = 16'd0;                        groups_sel = 3'd1; end
        2: begin dev_sel = 16'hFFFF;                     groups_sel = 3'd7; end
        3: begin dev_sel = TICK_W'($urandom_range(1, 12)); groups_sel = 3'd2; end
        4: begin dev_sel = TICK_W'($urandom);            groups_sel = 3'd3; end
        5: begin dev_sel = TICK_W'($urandom_range(0, 3)); groups_sel = 3'd0; end
        default: begin dev_sel = TICK_W'($urandom_range(0, 4)); groups_sel = 3'd5; end
      endcase
      write_config(dev_sel, groups_sel);
      count = (p == 5) ? 60 : (p == 6) ? 190 : 240;
      for (int i = 0; i < count; i++) begin
        random_item();
        if ($urandom_range(0, 149) == 0) drain();
      end
    end

    drain();
    repeat (70) @(posedge clk_i);
    if (mismatches == 0)
      $display("tick_periodic_task_dispatcher regression: pass");
    else
      $display("tick_periodic_task_dispatcher regression: fail");
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("tick_periodic_task_dispatcher regression: fail");
    $finish;
  end

endmodule
